>>> rtl/compressed_frame_header_window_parser_top_assert.svh
// Assertion macros for the frame header parser
`ifndef COMPRESSED_FRAME_HEADER_WINDOW_PARSER_TOP_ASSERT_SVH
`define COMPRESSED_FRAME_HEADER_WINDOW_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CFHWP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CFHWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cfhwp_pkg.sv
// Package: types, codes and helpers for the frame header parser
package cfhwp_pkg;

    localparam logic [31:0] MAGIC_MODERN    = 32'hFD2F_B528;
    localparam logic [31:0] MAGIC_LEGACY_LO = 32'hFD2F_B524;
    localparam logic [31:0] MAGIC_SKIP_BASE = 32'h184D_2A50;
    localparam logic [31:0] MAGIC_SKIP_MASK = 32'hFFFF_FFF0;
    localparam logic [63:0] LEGACY_CAP      = 64'h0000_0000_0800_0000;
    localparam logic [63:0] LEGACY_MIN_WIN  = 64'd1024;
    localparam int          MAX_WIN_W       = 43;

    typedef enum logic [1:0] {
        KIND_MODERN = 2'd0,
        KIND_LEGACY = 2'd1,
        KIND_SKIP   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MAGIC  = 3'd1,
        ST_RESERVED   = 3'd2,
        ST_TOO_LARGE  = 3'd3,
        ST_OVER_LIMIT = 3'd4,
        ST_TRUNCATED  = 3'd5
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  ver;
        logic [63:0] win;
        logic [4:0]  len;
        status_t     status;
    } result_t;

    // 4..7 for a legacy magic, else 0
    function automatic logic [2:0] legacy_ver(input logic [31:0] m);
        logic [2:0] v;
        v = 3'd0;
        if (m[31:2] == MAGIC_LEGACY_LO[31:2])
            v = {1'b1, m[1:0]};
        return v;
    endfunction

    // dictionary id length in bytes from descriptor bits 1:0
    function automatic logic [4:0] dict_len(input logic [1:0] code);
        logic [4:0] n;
        unique case (code)
            2'd0: n = 5'd0;
            2'd1: n = 5'd1;
            2'd2: n = 5'd2;
            default: n = 5'd4;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/cfhwp_parse.sv
// Header byte parser: frame state registers and per-byte result logic
module cfhwp_parse
    import cfhwp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  logic                 start_req,
    input  logic [7:0]           data_byte,
    input  logic [MAX_WIN_W-1:0] max_window,
    output logic                 res_valid,
    output result_t              res
);

    logic [4:0]  byte_count_reg, byte_count_next;
    logic [31:0] magic_word_reg, magic_word_next;
    logic [7:0]  frame_desc_reg, frame_desc_next;
    logic [63:0] csize_acc_reg, csize_acc_next;
    logic        active_reg, active_next;

    logic [4:0]  idx;
    logic [31:0] magic_base;
    logic [31:0] magic_new;
    logic [2:0]  ver;
    logic [2:0]  ver_new;
    logic [5:0]  wlog;
    logic [5:0]  wshift;
    logic [63:0] wd_win;
    logic [4:0]  off;
    logic [4:0]  fcs_len;
    logic [4:0]  rel;
    logic [63:0] csize_new;
    logic [63:0] fcs;
    logic [4:0]  last_idx;
    logic        raw_valid;
    result_t     raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            magic_word_reg <= '0;
            frame_desc_reg <= '0;
            csize_acc_reg  <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            magic_word_reg <= magic_word_next;
            frame_desc_reg <= frame_desc_next;
            csize_acc_reg  <= csize_acc_next;
            active_reg     <= active_next;
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        magic_word_next = magic_word_reg;
        frame_desc_next = frame_desc_reg;
        csize_acc_next  = csize_acc_reg;
        active_next     = active_reg;
        raw_valid       = 1'b0;
        raw             = '{kind: KIND_MODERN, ver: 3'd0, win: 64'd0, len: 5'd0,
                            status: ST_OK};

        idx        = start_req ? 5'd0 : byte_count_reg;
        magic_base = start_req ? 32'd0 : magic_word_reg;
        magic_new  = magic_base | ({24'd0, data_byte} << {idx[1:0], 3'b000});
        ver        = legacy_ver(magic_word_reg);
        ver_new    = legacy_ver(magic_new);

        // window descriptor: (8 + mantissa) << (exponent + 7)
        wlog   = {1'b0, data_byte[7:3]} + 6'd10;
        wshift = {1'b0, data_byte[7:3]} + 6'd7;
        wd_win = {60'd0, 1'b1, data_byte[2:0]} << wshift;

        off       = 5'd5 + dict_len(frame_desc_reg[1:0]);
        fcs_len   = 5'd1 << frame_desc_reg[7:6];
        last_idx  = off + fcs_len - 5'd1;
        rel       = idx - off;
        csize_new = csize_acc_reg | ({56'd0, data_byte} << {rel[2:0], 3'b000});
        fcs       = csize_new + ((frame_desc_reg[7:6] == 2'd1) ? 64'd256 : 64'd0);

        if (in_accept && (start_req || active_reg))
        begin
            if (start_req && active_reg)
            begin
                // restart while a header is open: report truncation
                raw_valid  = 1'b1;
                raw.status = ST_TRUNCATED;
                raw.len    = byte_count_reg;
                if (byte_count_reg >= 5'd4)
                begin
                    raw.ver  = ver;
                    raw.kind = (ver != 3'd0) ? KIND_LEGACY : KIND_MODERN;
                end
            end

            active_next     = 1'b1;
            byte_count_next = idx + 5'd1;
            if (start_req)
            begin
                frame_desc_next = '0;
                csize_acc_next  = '0;
            end

            if (idx < 5'd4)
            begin
                magic_word_next = magic_new;
                if (idx == 5'd3)
                begin
                    if ((magic_new & MAGIC_SKIP_MASK) == MAGIC_SKIP_BASE)
                    begin
                        raw_valid   = 1'b1;
                        raw.kind    = KIND_SKIP;
                        raw.len     = 5'd4;
                        active_next = 1'b0;
                    end
                    else if (magic_new != MAGIC_MODERN && ver_new == 3'd0)
                    begin
                        raw_valid   = 1'b1;
                        raw.len     = 5'd4;
                        raw.status  = ST_BAD_MAGIC;
                        active_next = 1'b0;
                    end
                end
            end
            else if (idx == 5'd4)
            begin
                frame_desc_next = data_byte;
                raw.ver  = ver;
                raw.kind = (ver != 3'd0) ? KIND_LEGACY : KIND_MODERN;
                raw.len  = 5'd5;
                if (ver == 3'd4 || ver == 3'd5)
                begin
                    raw_valid   = 1'b1;
                    active_next = 1'b0;
                    if (data_byte[7:4] != 4'd0)
                        raw.status = ST_RESERVED;
                    else
                        raw.win = 64'd1 << ({2'b00, data_byte[3:0]} + 6'd11);
                end
                else if (ver == 3'd6)
                begin
                    raw_valid   = 1'b1;
                    active_next = 1'b0;
                    if (data_byte[5])
                        raw.status = ST_RESERVED;
                    else
                        raw.win = 64'd1 << ({2'b00, data_byte[3:0]} + 6'd12);
                end
                else if (data_byte[3])
                begin
                    raw_valid   = 1'b1;
                    active_next = 1'b0;
                    raw.status  = ST_RESERVED;
                end
            end
            else if (!frame_desc_reg[5])
            begin
                raw_valid   = 1'b1;
                active_next = 1'b0;
                raw.ver     = ver;
                raw.kind    = (ver != 3'd0) ? KIND_LEGACY : KIND_MODERN;
                raw.len     = 5'd6;
                if (ver != 3'd0 && (wlog > 6'd27 || wd_win > LEGACY_CAP))
                    raw.status = ST_TOO_LARGE;
                else
                    raw.win = wd_win;
            end
            else if (idx >= off)
            begin
                csize_acc_next = csize_new;
                if (idx == last_idx)
                begin
                    raw_valid   = 1'b1;
                    active_next = 1'b0;
                    raw.ver     = ver;
                    raw.kind    = (ver != 3'd0) ? KIND_LEGACY : KIND_MODERN;
                    raw.len     = off + fcs_len;
                    if (ver == 3'd0)
                        raw.win = fcs;
                    else if (fcs > LEGACY_CAP)
                        raw.status = ST_TOO_LARGE;
                    else
                        raw.win = (fcs < LEGACY_MIN_WIN) ? LEGACY_MIN_WIN : fcs;
                end
            end
        end
    end

    // configured limit on legacy windows
    always_comb
    begin
        res       = raw;
        res_valid = raw_valid;
        if (raw.kind == KIND_LEGACY && raw.status == ST_OK && max_window != '0
            && raw.win > {{(64-MAX_WIN_W){1'b0}}, max_window})
        begin
            res.status = ST_OVER_LIMIT;
            res.win    = 64'd0;
        end
    end

endmodule

>>> rtl/cfhwp_outq.sv
// Two-entry result queue between the parser and the output channel
module cfhwp_outq
    import cfhwp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    head_valid,
    output logic    full,
    output result_t head
);

    logic [1:0] count_reg, count_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (pop && push)
                    head_next = push_data;
                else if (push)
                begin
                    tail_next  = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                    count_next = 2'd0;
            end
            2'd2:
            begin
                // no push while full
                if (pop)
                begin
                    head_next  = tail_reg;
                    count_next = 2'd1;
                end
            end
            default:
                count_next = 2'd0;
        endcase
    end

    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head       = head_reg;

endmodule

>>> rtl/compressed_frame_header_window_parser_top.sv
// Top level of the compressed frame header parser
// Takes one header byte per cycle (start_req marks a frame's first byte) and gives one
// result per completed or abandoned header: frame kind, legacy version, window size,
// header length and status. Each byte is parsed in the cycle it is transferred and its
// result, if any, enters a two-entry output queue, so a result appears on out_valid the
// cycle after the byte that finishes the header if no earlier result is queued. in_stall
// rises only when both queue entries are occupied; with the output side free, a byte is
// taken every cycle. max_window is written through the cfg port, which is always ready;
// write it only while no header is being parsed.
module compressed_frame_header_window_parser_top
    import cfhwp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 start_req,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           frame_kind,
    output logic [2:0]           legacy_version,
    output logic [63:0]          window_size,
    output logic [4:0]           header_length,
    output logic [2:0]           status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MAX_WIN_W-1:0] cfg_data
);

    `include "compressed_frame_header_window_parser_top_assert.svh"

    logic [MAX_WIN_W-1:0] max_window_reg;
    logic                 in_accept;
    logic                 out_accept;
    logic                 res_valid;
    logic                 q_full;
    result_t              res;
    result_t              head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_window_reg <= '0;
        else if (cfg_valid && cfg_ready)
            max_window_reg <= cfg_data;
    end

    assign in_stall   = q_full;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    cfhwp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .start_req  (start_req),
        .data_byte  (data_byte),
        .max_window (max_window_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    cfhwp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (out_accept),
        .head_valid (out_valid),
        .full       (q_full),
        .head       (head)
    );

    assign frame_kind     = head.kind;
    assign legacy_version = head.ver;
    assign window_size    = head.win;
    assign header_length  = head.len;
    assign status         = head.status;

    `CFHWP_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid, "stall with empty queue")
    `CFHWP_ASSERT_NOW(a_err_win_zero, out_valid && status != ST_OK, window_size == 64'd0, "error result carries a window")
    `CFHWP_ASSERT_NOW(a_skip_len, out_valid && frame_kind == KIND_SKIP, header_length == 5'd4 && window_size == 64'd0, "bad skippable result")
    `CFHWP_ASSERT_NOW(a_min_len, out_valid && status != ST_TRUNCATED, header_length >= 5'd4, "short header length")
    `CFHWP_ASSERT_NEXT(a_full_holds, q_full && out_stall, out_valid && in_stall, "full queue lost an entry")

endmodule
